/* design/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP request parser package
// Item types, status and tag codes, byte classes and the version digit step
// shared by the front, the queue and the back of the request parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // Parse status codes.
    localparam logic [1:0] STATUS_INDET = 2'd0;
    localparam logic [1:0] STATUS_GOOD  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Text tag codes.
    localparam logic [2:0] TAG_NONE   = 3'd0;
    localparam logic [2:0] TAG_METHOD = 3'd1;
    localparam logic [2:0] TAG_URI    = 3'd2;
    localparam logic [2:0] TAG_NAME   = 3'd3;
    localparam logic [2:0] TAG_VALUE  = 3'd4;

    // Command codes.
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // Byte values the parser looks for.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTL_MAX = 8'h1F;

    localparam logic [15:0] VERSION_MAX = 16'hFFFF;

    // One input item.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  parse_status;
        logic [2:0]  text_tag;
        logic [7:0]  text_byte;
        logic        header_begins;
        logic [15:0] version_major;
        logic [15:0] version_minor;
    } t_out_item;

    // Classification of one byte, worked out by the front.
    typedef struct packed {
        logic is_token;
        logic is_ctl;
        logic is_digit;
        logic is_sp;
        logic is_tab;
        logic is_cr;
        logic is_lf;
        logic is_colon;
        logic is_dot;
        logic is_slash;
        logic is_h;
        logic is_t;
        logic is_p;
    } t_cls;

    // One queue entry: the item and its byte classes.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        t_cls       cls;
    } t_q_item;

    // Separator characters that may not appear in a token.
    function automatic logic is_tspecial(input logic [7:0] b);
        logic r;
        unique case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Full class vector of a byte. Bytes with the top bit set are neither
    // token characters nor control characters.
    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c.is_ctl   = (b <= CH_CTL_MAX) || (b == CH_DEL);
        c.is_token = !b[7] && !c.is_ctl && !is_tspecial(b);
        c.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        c.is_sp    = (b == CH_SP);
        c.is_tab   = (b == CH_TAB);
        c.is_cr    = (b == CH_CR);
        c.is_lf    = (b == CH_LF);
        c.is_colon = (b == CH_COLON);
        c.is_dot   = (b == CH_DOT);
        c.is_slash = (b == CH_SLASH);
        c.is_h     = (b == CH_H);
        c.is_t     = (b == CH_T);
        c.is_p     = (b == CH_P);
        return c;
    endfunction

    // acc * 10 + digit, saturating at the 16-bit maximum.
    function automatic logic [15:0] acc_digit(input logic [15:0] acc,
                                              input logic [3:0]  digit);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, digit};
        return (v > {4'd0, VERSION_MAX}) ? VERSION_MAX : v[15:0];
    endfunction

endpackage

/* design/hrp_front.sv */
// ----------------------------------------------------------------------------
// HTTP request parser front
// Accepts input items while the queue has room and attaches the byte classes
// that the back needs, so the back only looks at single class bits.
// ----------------------------------------------------------------------------
module hrp_front
    import hrp_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_in_ready,
    output logic     o_push,
    output t_q_item  o_push_item
);

    // Accept whenever the queue has a free entry.
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the byte on its way into the queue.
    always_comb begin
        o_push_item.cmd       = i_in_data.cmd;
        o_push_item.data_byte = i_in_data.data_byte;
        o_push_item.cls       = classify(i_in_data.data_byte);
    end

endmodule

/* design/hrp_queue.sv */
// ----------------------------------------------------------------------------
// HTTP request parser queue
// Small first-in first-out buffer between the front and the back, so that
// either side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
module hrp_queue
    import hrp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_push_item,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_q_item o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers wrap at the last entry.
    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointer and occupancy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* design/hrp_back.sv */
// ----------------------------------------------------------------------------
// HTTP request parser back
// Runs the request state machine on one queued item per cycle while the output
// register can take it, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module hrp_back
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_q_item   i_item,
    input  logic      i_out_ready,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    typedef enum logic [4:0] {
        S_METHOD_START = 5'd0,
        S_METHOD       = 5'd1,
        S_URI          = 5'd2,
        S_VER_H        = 5'd3,
        S_VER_T1       = 5'd4,
        S_VER_T2       = 5'd5,
        S_VER_P        = 5'd6,
        S_VER_SLASH    = 5'd7,
        S_MAJOR_START  = 5'd8,
        S_MAJOR        = 5'd9,
        S_MINOR_START  = 5'd10,
        S_MINOR        = 5'd11,
        S_NL1          = 5'd12,
        S_LINE_START   = 5'd13,
        S_LWS          = 5'd14,
        S_NAME         = 5'd15,
        S_SPACE_VALUE  = 5'd16,
        S_VALUE        = 5'd17,
        S_NL2          = 5'd18,
        S_NL3          = 5'd19,
        S_DONE_GOOD    = 5'd20,
        S_DONE_BAD     = 5'd21
    } t_state;

    t_state      r_state;
    logic        r_hseen;
    logic [15:0] r_major;
    logic [15:0] r_minor;
    logic        r_out_valid;
    t_out_item   r_out_data;

    t_state      n_state;
    logic        n_hseen;
    logic [15:0] n_major;
    logic [15:0] n_minor;
    t_out_item   n_out;

    logic [1:0]  status;
    logic [2:0]  tag;
    logic        begins;
    t_cls        c;
    logic [3:0]  digit;

    // Take the head item whenever the output register is free or draining.
    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign c     = i_item.cls;
    assign digit = i_item.data_byte[3:0];

    // Next state and result of the head item.
    always_comb begin
        status  = STATUS_INDET;
        tag     = TAG_NONE;
        begins  = 1'b0;
        n_state = r_state;
        n_hseen = r_hseen;
        n_major = r_major;
        n_minor = r_minor;

        unique case (r_state)
            S_METHOD_START: begin
                if (c.is_token) begin
                    n_state = S_METHOD;
                    tag     = TAG_METHOD;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_METHOD: begin
                if (c.is_sp) begin
                    n_state = S_URI;
                end else if (c.is_token) begin
                    tag = TAG_METHOD;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_URI: begin
                if (c.is_sp) begin
                    n_state = S_VER_H;
                end else if (c.is_ctl) begin
                    status = STATUS_BAD;
                end else begin
                    tag = TAG_URI;
                end
            end
            S_VER_H: begin
                if (c.is_h) n_state = S_VER_T1; else status = STATUS_BAD;
            end
            S_VER_T1: begin
                if (c.is_t) n_state = S_VER_T2; else status = STATUS_BAD;
            end
            S_VER_T2: begin
                if (c.is_t) n_state = S_VER_P; else status = STATUS_BAD;
            end
            S_VER_P: begin
                if (c.is_p) n_state = S_VER_SLASH; else status = STATUS_BAD;
            end
            S_VER_SLASH: begin
                if (c.is_slash) begin
                    n_major = '0;
                    n_minor = '0;
                    n_state = S_MAJOR_START;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_MAJOR_START: begin
                if (c.is_digit) begin
                    n_major = acc_digit(r_major, digit);
                    n_state = S_MAJOR;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_MAJOR: begin
                if (c.is_dot) begin
                    n_state = S_MINOR_START;
                end else if (c.is_digit) begin
                    n_major = acc_digit(r_major, digit);
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_MINOR_START: begin
                if (c.is_digit) begin
                    n_minor = acc_digit(r_minor, digit);
                    n_state = S_MINOR;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_MINOR: begin
                if (c.is_cr) begin
                    n_state = S_NL1;
                end else if (c.is_digit) begin
                    n_minor = acc_digit(r_minor, digit);
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_NL1: begin
                if (c.is_lf) n_state = S_LINE_START; else status = STATUS_BAD;
            end
            S_LINE_START: begin
                if (c.is_cr) begin
                    n_state = S_NL3;
                end else if (r_hseen && (c.is_sp || c.is_tab)) begin
                    n_state = S_LWS;
                end else if (c.is_token) begin
                    n_hseen = 1'b1;
                    begins  = 1'b1;
                    tag     = TAG_NAME;
                    n_state = S_NAME;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_LWS: begin
                if (c.is_cr) begin
                    n_state = S_NL2;
                end else if (c.is_sp || c.is_tab) begin
                    n_state = S_LWS;
                end else if (c.is_ctl) begin
                    status = STATUS_BAD;
                end else begin
                    tag     = TAG_VALUE;
                    n_state = S_VALUE;
                end
            end
            S_NAME: begin
                if (c.is_colon) begin
                    n_state = S_SPACE_VALUE;
                end else if (c.is_token) begin
                    tag = TAG_NAME;
                end else begin
                    status = STATUS_BAD;
                end
            end
            S_SPACE_VALUE: begin
                if (c.is_sp) n_state = S_VALUE; else status = STATUS_BAD;
            end
            S_VALUE: begin
                if (c.is_cr) begin
                    n_state = S_NL2;
                end else if (c.is_ctl) begin
                    status = STATUS_BAD;
                end else begin
                    tag = TAG_VALUE;
                end
            end
            S_NL2: begin
                if (c.is_lf) n_state = S_LINE_START; else status = STATUS_BAD;
            end
            S_NL3: begin
                status = c.is_lf ? STATUS_GOOD : STATUS_BAD;
            end
            S_DONE_GOOD: begin
                status = STATUS_GOOD;
            end
            S_DONE_BAD: begin
                status = STATUS_BAD;
            end
            default: begin
                status = STATUS_BAD;
            end
        endcase

        // Good and bad are sticky end states.
        if (status == STATUS_GOOD) begin
            n_state = S_DONE_GOOD;
        end else if (status == STATUS_BAD) begin
            n_state = S_DONE_BAD;
        end

        n_out.parse_status  = status;
        n_out.text_tag      = tag;
        n_out.text_byte     = (tag != TAG_NONE) ? i_item.data_byte : 8'd0;
        n_out.header_begins = begins;
        n_out.version_major = n_major;
        n_out.version_minor = n_minor;

        // A reset command returns to the method start with an all-zero result.
        if (i_item.cmd == CMD_RESET) begin
            n_state = S_METHOD_START;
            n_hseen = 1'b0;
            n_major = '0;
            n_minor = '0;
            n_out   = '0;
        end
    end

    // Parser state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_METHOD_START;
            r_hseen     <= 1'b0;
            r_major     <= '0;
            r_minor     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_state     <= n_state;
            r_hseen     <= n_hseen;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_out_valid <= 1'b1;
            r_out_data  <= n_out;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* design/http_request_header_parser.sv */
// Throughput: one item per cycle while i_out_ready stays high; the back's
// state machine handles one byte per cycle and the queue absorbs up to
// QUEUE_DEPTH items while the output stalls.
// Reset: synchronous active-low i_rst_n empties the queue, drops the output
// valid and returns the parser to the method start with cleared versions.
// ----------------------------------------------------------------------------
// HTTP request header parser
// Byte-at-a-time HTTP request line and header parser: a classifying
// front, a short queue and a state-machine back with a registered output.
// ----------------------------------------------------------------------------
module http_request_header_parser
    import hrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic    q_push;
    t_q_item q_push_item;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_q_item q_head;

    // Input acceptance and byte classification.
    hrp_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_in_ready  (o_in_ready),
        .o_push      (q_push),
        .o_push_item (q_push_item)
    );

    // Decoupling queue.
    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    // Parser state machine and output register.
    hrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_item      (q_head),
        .i_out_ready (i_out_ready),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // A reset command yields an all-zero result.
    a_reset_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop && (q_head.cmd == CMD_RESET) |=> o_out_valid && (o_out_data == '0))
        else $error("reset command did not give an all-zero result");

    // Once bad, every further data byte stays bad.
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop && (q_head.cmd == CMD_DATA) && o_out_valid
        && (o_out_data.parse_status == STATUS_BAD)
        |=> o_out_data.parse_status == STATUS_BAD)
        else $error("bad status was not sticky");

    // Once good, every further data byte stays good.
    a_good_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop && (q_head.cmd == CMD_DATA) && o_out_valid
        && (o_out_data.parse_status == STATUS_GOOD)
        |=> o_out_data.parse_status == STATUS_GOOD)
        else $error("good status was not sticky");

    // A popped item always lands in the output register on the next edge.
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("popped item did not reach the output");
`endif

endmodule

/* sim/http_parse_checker.sv */
// ----------------------------------------------------------------------------
// HTTP request parser checker
// Watches both item channels of the request parser, predicts every result
// with its own model of the request state machine and compares the results
// field by field in arrival order.
// ----------------------------------------------------------------------------
module http_parse_checker
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending_count,
    output int        o_checked_count
);

    // Parser states of the prediction.
    typedef enum logic [4:0] {
        PS_METHOD_START,
        PS_METHOD,
        PS_URI,
        PS_VER_H,
        PS_VER_T1,
        PS_VER_T2,
        PS_VER_P,
        PS_VER_SLASH,
        PS_MAJOR_START,
        PS_MAJOR,
        PS_MINOR_START,
        PS_MINOR,
        PS_NL1,
        PS_LINE_START,
        PS_LWS,
        PS_NAME,
        PS_SPACE_VALUE,
        PS_VALUE,
        PS_NL2,
        PS_NL3,
        PS_DONE_GOOD,
        PS_DONE_BAD
    } t_parse_state;

    t_parse_state pstate      = PS_METHOD_START;
    logic         header_seen = 1'b0;
    logic [15:0]  major_acc   = '0;
    logic [15:0]  minor_acc   = '0;

    t_out_item pending_parse_results[$];
    int        fail_count    = 0;
    int        checked_count = 0;
    int        pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_count;
    assign o_checked_count = checked_count;

    // Control characters, tab included.
    function automatic logic byte_is_ctl(input logic [7:0] b);
        return (b <= CH_CTL_MAX) || (b == CH_DEL);
    endfunction

    // Characters that end a token.
    function automatic logic byte_is_separator(input logic [7:0] b);
        logic hit;
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", CH_SP, CH_TAB: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Bytes above 127 have the top bit set and never join a token.
    function automatic logic byte_is_token(input logic [7:0] b);
        return !b[7] && !byte_is_ctl(b) && !byte_is_separator(b);
    endfunction

    function automatic logic byte_is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // One more decimal digit of a version number, held at the 16-bit ceiling.
    function automatic logic [15:0] next_version(input logic [15:0] acc,
                                                 input logic [7:0]  b);
        logic [19:0] v;
        v = 20'(acc) * 20'd10 + 20'(b - CH_ZERO);
        return (v > 20'(VERSION_MAX)) ? VERSION_MAX : v[15:0];
    endfunction

    // Advances the predicted parser by one item and returns its result.
    function automatic t_out_item parse_byte(input t_in_item item);
        t_out_item    res;
        t_parse_state nxt;
        logic [7:0]   b;
        logic [2:0]   tag;
        logic [1:0]   status;
        logic         begins;
        b      = item.data_byte;
        tag    = TAG_NONE;
        status = STATUS_INDET;
        begins = 1'b0;
        nxt    = pstate;
        if (item.cmd == CMD_RESET) begin
            nxt         = PS_METHOD_START;
            header_seen = 1'b0;
            major_acc   = '0;
            minor_acc   = '0;
        end else begin
            case (pstate)
                PS_METHOD_START: begin
                    if (byte_is_token(b)) begin
                        nxt = PS_METHOD;
                        tag = TAG_METHOD;
                    end else status = STATUS_BAD;
                end
                PS_METHOD: begin
                    if (b == CH_SP) nxt = PS_URI;
                    else if (byte_is_token(b)) tag = TAG_METHOD;
                    else status = STATUS_BAD;
                end
                PS_URI: begin
                    if (b == CH_SP) nxt = PS_VER_H;
                    else if (byte_is_ctl(b)) status = STATUS_BAD;
                    else tag = TAG_URI;
                end
                PS_VER_H: begin
                    if (b == CH_H) nxt = PS_VER_T1;
                    else status = STATUS_BAD;
                end
                PS_VER_T1: begin
                    if (b == CH_T) nxt = PS_VER_T2;
                    else status = STATUS_BAD;
                end
                PS_VER_T2: begin
                    if (b == CH_T) nxt = PS_VER_P;
                    else status = STATUS_BAD;
                end
                PS_VER_P: begin
                    if (b == CH_P) nxt = PS_VER_SLASH;
                    else status = STATUS_BAD;
                end
                PS_VER_SLASH: begin
                    // The slash starts a fresh version number.
                    if (b == CH_SLASH) begin
                        major_acc = '0;
                        minor_acc = '0;
                        nxt       = PS_MAJOR_START;
                    end else status = STATUS_BAD;
                end
                PS_MAJOR_START: begin
                    if (byte_is_digit(b)) begin
                        major_acc = next_version(major_acc, b);
                        nxt       = PS_MAJOR;
                    end else status = STATUS_BAD;
                end
                PS_MAJOR: begin
                    if (b == CH_DOT) nxt = PS_MINOR_START;
                    else if (byte_is_digit(b)) major_acc = next_version(major_acc, b);
                    else status = STATUS_BAD;
                end
                PS_MINOR_START: begin
                    if (byte_is_digit(b)) begin
                        minor_acc = next_version(minor_acc, b);
                        nxt       = PS_MINOR;
                    end else status = STATUS_BAD;
                end
                PS_MINOR: begin
                    if (b == CH_CR) nxt = PS_NL1;
                    else if (byte_is_digit(b)) minor_acc = next_version(minor_acc, b);
                    else status = STATUS_BAD;
                end
                PS_NL1: begin
                    if (b == CH_LF) nxt = PS_LINE_START;
                    else status = STATUS_BAD;
                end
                PS_LINE_START: begin
                    // Leading whitespace continues the previous header value.
                    if (b == CH_CR) nxt = PS_NL3;
                    else if (header_seen && (b == CH_SP || b == CH_TAB)) nxt = PS_LWS;
                    else if (byte_is_token(b)) begin
                        header_seen = 1'b1;
                        begins      = 1'b1;
                        tag         = TAG_NAME;
                        nxt         = PS_NAME;
                    end else status = STATUS_BAD;
                end
                PS_LWS: begin
                    if (b == CH_CR) nxt = PS_NL2;
                    else if (b == CH_SP || b == CH_TAB) nxt = PS_LWS;
                    else if (byte_is_ctl(b)) status = STATUS_BAD;
                    else begin
                        tag = TAG_VALUE;
                        nxt = PS_VALUE;
                    end
                end
                PS_NAME: begin
                    if (b == CH_COLON) nxt = PS_SPACE_VALUE;
                    else if (byte_is_token(b)) tag = TAG_NAME;
                    else status = STATUS_BAD;
                end
                PS_SPACE_VALUE: begin
                    if (b == CH_SP) nxt = PS_VALUE;
                    else status = STATUS_BAD;
                end
                PS_VALUE: begin
                    if (b == CH_CR) nxt = PS_NL2;
                    else if (byte_is_ctl(b)) status = STATUS_BAD;
                    else tag = TAG_VALUE;
                end
                PS_NL2: begin
                    if (b == CH_LF) nxt = PS_LINE_START;
                    else status = STATUS_BAD;
                end
                PS_NL3: begin
                    status = (b == CH_LF) ? STATUS_GOOD : STATUS_BAD;
                end
                PS_DONE_GOOD: begin
                    status = STATUS_GOOD;
                end
                default: begin
                    status = STATUS_BAD;
                end
            endcase
            // Good and bad are sticky until the next reset command.
            if (status == STATUS_GOOD) nxt = PS_DONE_GOOD;
            else if (status == STATUS_BAD) nxt = PS_DONE_BAD;
        end
        pstate = nxt;

        res.parse_status  = status;
        res.text_tag      = tag;
        res.text_byte     = (tag != TAG_NONE) ? b : 8'h00;
        res.header_begins = begins;
        res.version_major = major_acc;
        res.version_minor = minor_acc;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Both channels are sampled at the falling edge before the rising edge
    // that completes a handshake, so all signals are settled.
    always @(negedge i_clk) begin
        t_out_item want;
        t_out_item predicted;
        if (!i_rst_n) begin
            pstate      = PS_METHOD_START;
            header_seen = 1'b0;
            major_acc   = '0;
            minor_acc   = '0;
            pending_parse_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_parse_results.size() == 0) begin
                    $error("Result item with no prediction pending");
                    fail_count++;
                end else begin
                    want = pending_parse_results.pop_front();
                    check_field("parse_status", 16'(want.parse_status),
                                16'(i_out_data.parse_status));
                    check_field("text_tag", 16'(want.text_tag),
                                16'(i_out_data.text_tag));
                    check_field("text_byte", 16'(want.text_byte),
                                16'(i_out_data.text_byte));
                    check_field("header_begins", 16'(want.header_begins),
                                16'(i_out_data.header_begins));
                    check_field("version_major", want.version_major,
                                i_out_data.version_major);
                    check_field("version_minor", want.version_minor,
                                i_out_data.version_minor);
                end
                checked_count++;
            end
            if (i_in_valid && i_in_ready) begin
                predicted = parse_byte(i_in_data);
                pending_parse_results.insert(pending_parse_results.size(), predicted);
            end
        end
        pending_count = pending_parse_results.size();
    end

endmodule

/* sim/tb_http_request_header_parser.sv */
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Feeds the parser a short directed byte sequence, then random requests,
// corrupted requests and noise bursts under four mixes of sender idling and
// receiver stalls; the checker beside the parser predicts and compares.
// ----------------------------------------------------------------------------
module tb_http_request_header_parser;
    import hrp_pkg::*;

    localparam int PHASE_ITEMS = 190;
    localparam int RUN_LIMIT   = 1_000_000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending_count;
    int checked_count;

    int items_sent      = 0;
    int requests_sent   = 0;
    int requests_broken = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int idle_plan[4]    = '{0, 75, 0, 35};
    int stall_plan[4]   = '{0, 0, 75, 35};

    string      token_chars =
        "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    logic [7:0] request_bytes[$];

    http_request_header_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    http_parse_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one item and returns at the rising edge that accepts it.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        t_in_item item;
        bit       taken;
        item.cmd       = cmd;
        item.data_byte = b;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(CMD_DATA, s[i]);
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
    endtask

    // Adds one byte to the end of the request under construction.
    function automatic void append_byte(input logic [7:0] v);
        request_bytes.insert(request_bytes.size(), v);
    endfunction

    function automatic void push_tokens(input int count);
        repeat (count) append_byte(token_chars[$urandom_range(token_chars.len() - 1)]);
    endfunction

    // Printable or high bytes; never a control character.
    function automatic void push_text(input int count, input bit allow_space);
        logic [7:0] v;
        repeat (count) begin
            v = 8'($urandom_range(255, 32));
            if (v == CH_DEL) v = 8'hA0;
            if (!allow_space && v == CH_SP) v = CH_SLASH;
            append_byte(v);
        end
    endfunction

    // Mostly short version numbers, now and then long enough to saturate.
    function automatic void push_digits();
        int count;
        count = ($urandom_range(7) == 0) ? $urandom_range(7, 5) : $urandom_range(2, 1);
        repeat (count) append_byte(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endfunction

    function automatic void push_crlf();
        append_byte(CH_CR);
        append_byte(CH_LF);
    endfunction

    // Builds one well-formed request with random content.
    function automatic void build_request();
        request_bytes.delete();
        push_tokens($urandom_range(4, 1));
        append_byte(CH_SP);
        push_text($urandom_range(6, 1), 1'b0);
        append_byte(CH_SP);
        push_string("HTTP/");
        push_digits();
        append_byte(CH_DOT);
        push_digits();
        push_crlf();
        repeat ($urandom_range(3)) begin
            push_tokens($urandom_range(4, 1));
            push_string(": ");
            push_text($urandom_range(5), 1'b1);
            push_crlf();
            // Continuation line of the same value.
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(2, 1)) begin
                    append_byte(($urandom_range(1) == 0) ? CH_SP : CH_TAB);
                end
                push_text($urandom_range(4), 1'b1);
                push_crlf();
            end
        end
        push_crlf();
    endfunction

    // One request after a reset command, sometimes with one byte replaced,
    // followed by a few bytes that land in the final state.
    task automatic run_request();
        int pos;
        build_request();
        if ($urandom_range(3) == 0) begin
            pos = $urandom_range(request_bytes.size() - 1);
            request_bytes[pos] = 8'($urandom);
            requests_broken++;
        end
        send_item(CMD_RESET, 8'($urandom));
        foreach (request_bytes[i]) send_item(CMD_DATA, request_bytes[i]);
        repeat ($urandom_range(3)) send_item(CMD_DATA, 8'($urandom));
        requests_sent++;
    endtask

    task automatic run_noise();
        repeat ($urandom_range(8, 1)) begin
            send_item(($urandom_range(15) == 0) ? CMD_RESET : CMD_DATA, 8'($urandom));
        end
    endtask

    // Reset, directed bytes, then the random phases and the verdict.
    initial begin
        int phase_end;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset command with a set data byte, a high byte in the URI, a
        // saturating major version, a tab in a header value that makes the status
        // bad, one byte after the bad status and a final reset command.
        send_item(CMD_RESET, 8'hFF);
        send_text("G ");
        send_item(CMD_DATA, 8'hFF);
        send_text(" HTTP/99999.0");
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, CH_LF);
        send_text("a: x");
        send_item(CMD_DATA, CH_TAB);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_RESET, 8'h00);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_plan[phase];
            recv_stall_pct <= stall_plan[phase];
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(7) == 0) run_noise();
                else run_request();
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d items: %0d requests, %0d of them corrupted, plus noise bursts.",
                 items_sent, requests_sent, requests_broken);
        $display("Checked %0d results across four sender and receiver pacing mixes.",
                 checked_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
